### rtl/cubic_curve_line_rasterizer_macros.svh
// assertion macros used by the checker file
`ifndef CUBIC_CURVE_LINE_RASTERIZER_MACROS_SVH
`define CUBIC_CURVE_LINE_RASTERIZER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CCL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ccl check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define CCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ccl check failed");

`endif

### rtl/ccl_pkg.sv
`default_nettype none
package ccl_pkg;

  localparam int FracBits    = 16;
  localparam int MaxSegments = 64;
  localparam int CoordBits   = 12;
  localparam int SegW        = 7;
  localparam int CoefW       = 32;
  localparam int NumCoefs    = 8;
  localparam int CoefIdxW    = 3;
  localparam int ColorW      = 24;
  localparam int ScaleW      = 10;
  localparam int OffW        = 13;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 13;
  // working width of pixel-space values in Q16
  localparam int ValW        = 48;
  localparam int TW          = FracBits + 1;
  localparam int SlopeW      = TW + 1;
  localparam int ProdW       = ValW + TW;
  localparam int DvdW        = SegW + FracBits;
  localparam int QuotW       = 24;
  localparam int StepW       = 5;
  localparam int PxW         = ValW - FracBits;
  localparam int InDataW     = CoefW * NumCoefs + ColorW;
  localparam int OutDataW    = 2 * CoordBits + ColorW;

  localparam logic [StepW-1:0] DivStepsT     = StepW'(DvdW);
  localparam logic [StepW-1:0] DivStepsSlope = StepW'(FracBits);

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgScale   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOffX    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOffY    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSegs    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCanvasW = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCanvasH = 3'd5;

  // request kinds
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  // horner term codes
  localparam logic [1:0] TermA = 2'd0;
  localparam logic [1:0] TermD = 2'd3;

  typedef struct packed {
    logic       load;
    logic       tick;
    logic       post;
    logic       div_t;
    logic       t_sel;
    logic       cap_t;
    logic       hor_init;
    logic       mul_hor;
    logic       hor_add;
    logic [1:0] term;
    logic [1:0] pt_sel;
    logic       geom;
    logic       slope;
    logic       cap_slope;
    logic       mul_q;
    logic       cap_minor;
    logic       seg_next;
    logic       set_fin;
  } ccl_cmd_t;

  typedef struct packed {
    logic fin;
    logic seg_end;
    logic last_seg;
    logic range_ok;
    logic need_div;
    logic mul_busy;
    logic div_busy;
  } ccl_status_t;

  // Q16 to pixel, truncating toward zero
  function automatic logic signed [PxW-1:0] trunc_px(input logic signed [ValW-1:0] v);
    logic signed [ValW-1:0] m;
    logic signed [PxW-1:0]  r;
    m = v[ValW-1] ? -v : v;
    r = m[ValW-1:FracBits];
    return v[ValW-1] ? -r : r;
  endfunction

endpackage
`default_nettype wire

### rtl/ccl_mul.sv
`default_nettype none
module ccl_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ccl_pkg::ValW-1:0]   mcand_i,
  input  logic        [ccl_pkg::TW-1:0]     mplier_i,
  output logic                              busy_o,
  output logic signed [ccl_pkg::ProdW-1:0]  prod_o
);
  import ccl_pkg::*;

  localparam int CntW = $clog2(TW + 1);

  logic                    busy_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [ProdW-1:0] acc_q, mc_q;
  logic [TW-1:0]           mp_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(TW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  // shift-add, one multiplier bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mc_q  <= ProdW'(mcand_i);
      mp_q  <= mplier_i;
    end else if (busy_q) begin
      if (mp_q[0]) acc_q <= acc_q + mc_q;
      mc_q <= mc_q <<< 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

### rtl/ccl_div.sv
`default_nettype none
module ccl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ccl_pkg::ValW-1:0]      rem_i,
  input  logic [ccl_pkg::DvdW-1:0]      dvd_i,
  input  logic [ccl_pkg::ValW-1:0]      den_i,
  input  logic [ccl_pkg::StepW-1:0]     steps_i,
  output logic                          busy_o,
  output logic [ccl_pkg::QuotW-1:0]     quot_o
);
  import ccl_pkg::*;

  logic              busy_q;
  logic [StepW-1:0]  cnt_q;
  logic [ValW-1:0]   rem_q, den_q;
  logic [DvdW-1:0]   dv_q;
  logic [QuotW-1:0]  quot_q;
  logic [ValW:0]     r2;
  logic              ge;

  // restoring step
  always_comb begin
    r2 = {rem_q, dv_q[DvdW-1]};
    ge = r2 >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      dv_q   <= dvd_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? ValW'(r2 - {1'b0, den_q}) : r2[ValW-1:0];
      dv_q   <= dv_q << 1;
      quot_q <= {quot_q[QuotW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

### rtl/ccl_datapath.sv
`default_nettype none
module ccl_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic [ccl_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  logic [ccl_pkg::CfgDataW-1:0]           cfg_data_i,
  input  logic [ccl_pkg::CoefW*ccl_pkg::NumCoefs-1:0] coefs_i,
  input  logic [ccl_pkg::ColorW-1:0]             color_i,
  input  ccl_pkg::ccl_cmd_t                      cmd_i,
  output ccl_pkg::ccl_status_t                   status_o,
  output logic [ccl_pkg::CoordBits-1:0]          pixel_x_o,
  output logic [ccl_pkg::CoordBits-1:0]          pixel_y_o,
  output logic [ccl_pkg::ColorW-1:0]             pixel_color_o,
  output logic                                   write_enable_o,
  output logic                                   curve_done_o
);
  import ccl_pkg::*;

  // config registers
  logic [ScaleW-1:0]           scale_q;
  logic signed [OffW-1:0]      offx_q, offy_q;
  logic [SegW-1:0]             segc_q;
  logic [CoordBits-1:0]        cw_q, ch_q;

  // curve and segment state
  logic signed [CoefW-1:0]     coef_q [NumCoefs];
  logic [ColorW-1:0]           color_q;
  logic [SegW-1:0]             seg_q;
  logic                        fin_q;
  logic [TW-1:0]               tp_q, tq_q;
  logic signed [ValW-1:0]      acc_q;
  logic signed [ValW-1:0]      pt_q [4];
  logic                        xmaj_q, ok_q;
  logic signed [ValW-1:0]      smj_q, smn_q, dmn_q;
  logic [ValW-1:0]             dmj_q;
  logic [CoordBits-1:0]        lo_q, end_q, pos_q;
  logic signed [SlopeW-1:0]    slope_q;
  logic signed [ValW-1:0]      minor_q;

  // result registers
  logic [CoordBits-1:0]        res_x_q, res_y_q;
  logic [ColorW-1:0]           res_color_q;
  logic                        res_we_q, res_done_q;

  // shared units
  logic                        mul_start, mul_busy;
  logic signed [ValW-1:0]      mul_mc;
  logic [TW-1:0]               mul_mp;
  logic signed [ProdW-1:0]     mul_prod;
  logic                        div_start, div_busy;
  logic [ValW-1:0]             div_rem, div_den;
  logic [DvdW-1:0]             div_dvd;
  logic [StepW-1:0]            div_steps;
  logic [QuotW-1:0]            div_quot;

  logic [SegW-1:0]             n_seg, seg_sel;
  logic [DvdW-1:0]             t_num;
  logic signed [ValW-1:0]      diff, diff_abs, dmn_abs;
  logic [SlopeW-1:0]           slope_abs;
  logic                        need_div;

  // effective segment count
  always_comb begin
    if (segc_q == '0) n_seg = SegW'(1);
    else if (segc_q > SegW'(MaxSegments)) n_seg = SegW'(MaxSegments);
    else n_seg = segc_q;
  end

  // operand selection for multiplier and divider
  always_comb begin
    diff      = $signed({{(ValW-CoordBits-FracBits){1'b0}}, lo_q, {FracBits{1'b0}}}) - smj_q;
    diff_abs  = diff[ValW-1] ? -diff : diff;
    slope_abs = slope_q[SlopeW-1] ? SlopeW'(-slope_q) : SlopeW'(slope_q);
    dmn_abs   = dmn_q[ValW-1] ? -dmn_q : dmn_q;
    need_div  = (dmj_q != '0) && ($unsigned(dmn_abs) < dmj_q);
    mul_start = cmd_i.mul_hor | cmd_i.mul_q;
    mul_mc    = cmd_i.mul_q ? diff_abs : acc_q;
    mul_mp    = cmd_i.mul_q ? slope_abs[TW-1:0] : (cmd_i.pt_sel[1] ? tq_q : tp_q);
    seg_sel   = cmd_i.t_sel ? seg_q + SegW'(1) : seg_q;
    t_num     = {seg_sel, {FracBits{1'b0}}} + DvdW'(n_seg >> 1);
    div_start = cmd_i.div_t | (cmd_i.slope & need_div);
    div_rem   = cmd_i.div_t ? '0 : $unsigned(dmn_abs);
    div_dvd   = cmd_i.div_t ? t_num : '0;
    div_den   = cmd_i.div_t ? {{(ValW-SegW){1'b0}}, n_seg} : dmj_q;
    div_steps = cmd_i.div_t ? DivStepsT : DivStepsSlope;
  end

  ccl_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mc),
    .mplier_i (mul_mp),
    .busy_o   (mul_busy),
    .prod_o   (mul_prod)
  );

  ccl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .dvd_i   (div_dvd),
    .den_i   (div_den),
    .steps_i (div_steps),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // scaled coefficient for the current term and axis
  logic signed [CoefW-1:0]        coef_sel;
  logic signed [CoefW+ScaleW:0]   scl_prod;
  logic signed [ValW-1:0]         scl_ext, scl_axis, off_ext, term_val, hor_sum;
  logic signed [OffW-1:0]         off_sel;

  always_comb begin
    coef_sel = coef_q[{cmd_i.term, cmd_i.pt_sel[0]}];
    scl_prod = coef_sel * $signed({1'b0, scale_q});
    scl_ext  = ValW'(scl_prod);
    scl_axis = cmd_i.pt_sel[0] ? -scl_ext : scl_ext;
    off_sel  = cmd_i.pt_sel[0] ? offy_q : offx_q;
    off_ext  = $signed({{(ValW-OffW-FracBits){off_sel[OffW-1]}}, off_sel, {FracBits{1'b0}}});
    term_val = scl_axis + ((cmd_i.term == TermD) ? off_ext : '0);
    hor_sum  = $signed(mul_prod[ValW+FracBits-1:FracBits]) + term_val;
  end

  // segment geometry from the two evaluated endpoints
  logic signed [ValW-1:0] dx, dy, adx, ady, pm, qm, pn, qn, s_mj, s_mn, e_mj, e_mn;
  logic signed [PxW-1:0]  lim, tl, th, lo_c, hi_c;
  logic                   xm, swap;

  always_comb begin
    dx   = pt_q[2] - pt_q[0];
    dy   = pt_q[3] - pt_q[1];
    adx  = dx[ValW-1] ? -dx : dx;
    ady  = dy[ValW-1] ? -dy : dy;
    xm   = (dx != '0) && ($unsigned(ady) <= $unsigned(adx));
    pm   = xm ? pt_q[0] : pt_q[1];
    qm   = xm ? pt_q[2] : pt_q[3];
    pn   = xm ? pt_q[1] : pt_q[0];
    qn   = xm ? pt_q[3] : pt_q[2];
    swap = pm > qm;
    s_mj = swap ? qm : pm;
    s_mn = swap ? qn : pn;
    e_mj = swap ? pm : qm;
    e_mn = swap ? pn : qn;
    lim  = $signed({{(PxW-CoordBits){1'b0}}, (xm ? cw_q : ch_q)}) - PxW'(1);
    tl   = trunc_px(s_mj);
    th   = trunc_px(e_mj);
    lo_c = tl[PxW-1] ? '0 : tl;
    hi_c = (th > lim) ? lim : th;
  end

  // pixel slot of the current step
  logic signed [PxW-1:0]  minor_px;
  logic [CoordBits-1:0]   lim_t;
  logic                   vis;

  always_comb begin
    minor_px = trunc_px(minor_q);
    lim_t    = xmaj_q ? ch_q : cw_q;
    vis      = !minor_px[PxW-1] &&
               (minor_px < $signed({{(PxW-CoordBits){1'b0}}, lim_t}));
  end

  // control state and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleW'(100);
      offx_q  <= OffW'(450);
      offy_q  <= OffW'(349);
      segc_q  <= SegW'(30);
      cw_q    <= CoordBits'(900);
      ch_q    <= CoordBits'(600);
      fin_q   <= 1'b1;
      seg_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgScale:   scale_q <= cfg_data_i[ScaleW-1:0];
          CfgOffX:    offx_q  <= $signed(cfg_data_i[OffW-1:0]);
          CfgOffY:    offy_q  <= $signed(cfg_data_i[OffW-1:0]);
          CfgSegs:    segc_q  <= cfg_data_i[SegW-1:0];
          CfgCanvasW: cw_q    <= cfg_data_i[CoordBits-1:0];
          CfgCanvasH: ch_q    <= cfg_data_i[CoordBits-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        fin_q <= 1'b0;
        seg_q <= '0;
      end
      if (cmd_i.seg_next) seg_q <= seg_q + SegW'(1);
      if (cmd_i.set_fin)  fin_q <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < NumCoefs; k++) begin
        coef_q[k] <= $signed(coefs_i[k*CoefW +: CoefW]);
      end
      color_q <= color_i;
    end
    if (cmd_i.cap_t) begin
      if (cmd_i.t_sel) tq_q <= div_quot[TW-1:0];
      else tp_q <= div_quot[TW-1:0];
    end
    if (cmd_i.hor_init) acc_q <= term_val;
    if (cmd_i.hor_add) begin
      acc_q <= hor_sum;
      if (cmd_i.term == TermD) pt_q[cmd_i.pt_sel] <= hor_sum;
    end
    if (cmd_i.geom) begin
      xmaj_q <= xm;
      smj_q  <= s_mj;
      smn_q  <= s_mn;
      dmj_q  <= $unsigned(e_mj - s_mj);
      dmn_q  <= e_mn - s_mn;
      lo_q   <= lo_c[CoordBits-1:0];
      end_q  <= hi_c[CoordBits-1:0];
      ok_q   <= lo_c <= hi_c;
    end
    // slope: zero length, full step, or divider result
    if (cmd_i.slope && !need_div) begin
      if (dmj_q == '0) slope_q <= '0;
      else if (dmn_q[ValW-1]) slope_q <= -$signed({2'b01, {FracBits{1'b0}}});
      else slope_q <= $signed({2'b01, {FracBits{1'b0}}});
    end
    if (cmd_i.cap_slope) begin
      slope_q <= dmn_q[ValW-1] ? -$signed({2'b00, div_quot[FracBits-1:0]})
                               :  $signed({2'b00, div_quot[FracBits-1:0]});
    end
    if (cmd_i.cap_minor) begin
      pos_q   <= lo_q;
      minor_q <= smn_q + ((slope_q[SlopeW-1] ^ diff[ValW-1])
                 ? -$signed(mul_prod[ValW+FracBits-1:FracBits])
                 :  $signed(mul_prod[ValW+FracBits-1:FracBits]));
    end
    // one pixel slot per tick
    if (cmd_i.tick) begin
      res_x_q     <= '0;
      res_y_q     <= '0;
      res_color_q <= '0;
      res_we_q    <= 1'b0;
      if (!fin_q) begin
        if (vis) begin
          res_x_q     <= xmaj_q ? pos_q : minor_px[CoordBits-1:0];
          res_y_q     <= xmaj_q ? minor_px[CoordBits-1:0] : pos_q;
          res_color_q <= color_q;
          res_we_q    <= 1'b1;
        end
        pos_q   <= pos_q + CoordBits'(1);
        minor_q <= minor_q + ValW'(slope_q);
      end
    end
    if (cmd_i.post) res_done_q <= fin_q;
  end

  always_comb begin
    status_o.fin      = fin_q;
    status_o.seg_end  = ({1'b0, pos_q} + (CoordBits+1)'(1)) > {1'b0, end_q};
    status_o.last_seg = ({1'b0, seg_q} + (SegW+1)'(1)) >= {1'b0, n_seg};
    status_o.range_ok = ok_q;
    status_o.need_div = need_div;
    status_o.mul_busy = mul_busy;
    status_o.div_busy = div_busy;
  end

  assign pixel_x_o      = res_x_q;
  assign pixel_y_o      = res_y_q;
  assign pixel_color_o  = res_color_q;
  assign write_enable_o = res_we_q;
  assign curve_done_o   = res_done_q;

endmodule
`default_nettype wire

### rtl/ccl_ctrl.sv
`default_nettype none
module ccl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_kind_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ccl_pkg::ccl_status_t  status_i,
  output ccl_pkg::ccl_cmd_t     cmd_o
);
  import ccl_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StTDiv  = 4'd1;
  localparam logic [3:0] StTWait = 4'd2;
  localparam logic [3:0] StHInit = 4'd3;
  localparam logic [3:0] StHMul  = 4'd4;
  localparam logic [3:0] StHWait = 4'd5;
  localparam logic [3:0] StGeom  = 4'd6;
  localparam logic [3:0] StChk   = 4'd7;
  localparam logic [3:0] StSlope = 4'd8;
  localparam logic [3:0] StSWait = 4'd9;
  localparam logic [3:0] StMulQ  = 4'd10;
  localparam logic [3:0] StMWait = 4'd11;
  localparam logic [3:0] StNext  = 4'd12;
  localparam logic [3:0] StFin   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       tsel_q, tsel_d;
  logic [1:0] pt_q, pt_d;
  logic [1:0] term_q, term_d;
  logic       ovalid_q, ovalid_d;
  logic       tick_q, tick_d;
  logic       accept;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle) && !ovalid_q;
  assign out_valid_o = ovalid_q;

  // sequencer
  always_comb begin
    state_d  = state_q;
    tsel_d   = tsel_q;
    pt_d     = pt_q;
    term_d   = term_q;
    tick_d   = tick_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o        = '0;
    cmd_o.t_sel  = tsel_q;
    cmd_o.pt_sel = pt_q;
    cmd_o.term   = term_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_kind_i == CmdLoad) begin
            cmd_o.load = 1'b1;
            tick_d     = 1'b0;
            tsel_d     = 1'b0;
            state_d    = StTDiv;
          end else begin
            cmd_o.tick = 1'b1;
            if (!status_i.fin && status_i.seg_end) begin
              tick_d  = 1'b1;
              state_d = StNext;
            end else begin
              cmd_o.post = 1'b1;
              ovalid_d   = 1'b1;
            end
          end
        end
      end
      StTDiv: begin
        cmd_o.div_t = 1'b1;
        state_d     = StTWait;
      end
      StTWait: begin
        if (!status_i.div_busy) begin
          cmd_o.cap_t = 1'b1;
          if (!tsel_q) begin
            tsel_d  = 1'b1;
            state_d = StTDiv;
          end else begin
            pt_d    = '0;
            state_d = StHInit;
          end
        end
      end
      StHInit: begin
        cmd_o.hor_init = 1'b1;
        cmd_o.term     = TermA;
        term_d         = 2'd1;
        state_d        = StHMul;
      end
      StHMul: begin
        cmd_o.mul_hor = 1'b1;
        state_d       = StHWait;
      end
      StHWait: begin
        if (!status_i.mul_busy) begin
          cmd_o.hor_add = 1'b1;
          if (term_q == TermD) begin
            pt_d    = pt_q + 2'd1;
            state_d = (pt_q == 2'd3) ? StGeom : StHInit;
          end else begin
            term_d  = term_q + 2'd1;
            state_d = StHMul;
          end
        end
      end
      StGeom: begin
        cmd_o.geom = 1'b1;
        state_d    = StChk;
      end
      StChk: begin
        state_d = status_i.range_ok ? StSlope : StNext;
      end
      StSlope: begin
        cmd_o.slope = 1'b1;
        state_d     = status_i.need_div ? StSWait : StMulQ;
      end
      StSWait: begin
        if (!status_i.div_busy) begin
          cmd_o.cap_slope = 1'b1;
          state_d         = StMulQ;
        end
      end
      StMulQ: begin
        cmd_o.mul_q = 1'b1;
        state_d     = StMWait;
      end
      StMWait: begin
        if (!status_i.mul_busy) begin
          cmd_o.cap_minor = 1'b1;
          state_d         = StFin;
        end
      end
      StNext: begin
        if (status_i.last_seg) begin
          cmd_o.set_fin = 1'b1;
          state_d       = StFin;
        end else begin
          cmd_o.seg_next = 1'b1;
          tsel_d         = 1'b0;
          state_d        = StTDiv;
        end
      end
      StFin: begin
        if (tick_q) begin
          cmd_o.post = 1'b1;
          ovalid_d   = 1'b1;
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      tsel_q   <= 1'b0;
      pt_q     <= '0;
      term_q   <= '0;
      ovalid_q <= 1'b0;
      tick_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      tsel_q   <= tsel_d;
      pt_q     <= pt_d;
      term_q   <= term_d;
      ovalid_q <= ovalid_d;
      tick_q   <= tick_d;
    end
  end

endmodule
`default_nettype wire

### rtl/cubic_curve_line_rasterizer.sv
// channel    | dir | handshake                     | payload
// s_axis     | in  | s_axis_tvalid / s_axis_tready | tdata coefs and color, tuser kind
// m_axis     | out | m_axis_tvalid / m_axis_tready | tdata pixel, tuser write, tlast done
// cfg        | in  | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// a tick that stays inside its segment is answered from the idle state
// a load, or a tick that ends a segment, starts a segment set up made of:
// two 23-step t divisions, thirteen 17-step serial multiplies, a 16-step slope divide
// a tick result waits in the output register; no request is taken while it is full
// rst_ni clears control state and loads the register defaults; no curve is drawn after reset
`default_nettype none
module cubic_curve_line_rasterizer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // coef_ax, coef_ay, coef_bx, coef_by, coef_cx, coef_cy, coef_dx, coef_dy, color
  input  logic [ccl_pkg::InDataW-1:0]      s_axis_tdata,
  // cmd
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [ccl_pkg::OutDataW-1:0]     m_axis_tdata,
  // write_enable
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ccl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ccl_pkg::CfgDataW-1:0]     cfg_data_i
);
  import ccl_pkg::*;

  ccl_cmd_t             cmd;
  ccl_status_t          status;
  logic [CoordBits-1:0] px, py;
  logic [ColorW-1:0]    pcol;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  ccl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ccl_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_we),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .coefs_i        (s_axis_tdata[CoefW*NumCoefs-1:0]),
    .color_i        (s_axis_tdata[InDataW-1:CoefW*NumCoefs]),
    .cmd_i          (cmd),
    .status_o       (status),
    .pixel_x_o      (px),
    .pixel_y_o      (py),
    .pixel_color_o  (pcol),
    .write_enable_o (m_axis_tuser),
    .curve_done_o   (m_axis_tlast)
  );

  // output packing, pixel_x lowest
  assign m_axis_tdata = {pcol, py, px};

endmodule
`default_nettype wire

### rtl/ccl_checker.sv
`default_nettype none
`include "cubic_curve_line_rasterizer_macros.svh"
module ccl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ccl_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser
);
  import ccl_pkg::*;

  // a stalled result stays offered
  `CCL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // no request is taken while a result waits
  `CCL_ASSERT_NOW(a_busy_out, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  // idle or clipped slots carry zero payload
  `CCL_ASSERT_NOW(a_idle_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
  // a load gives no result
  `CCL_ASSERT_NEXT(a_load_quiet, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CmdLoad), !m_axis_tvalid)

endmodule

bind cubic_curve_line_rasterizer ccl_checker u_ccl_checker (.*);
`default_nettype wire
